>>> hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int LEN_W          = 24;
	localparam int QDEPTH         = 4;

	localparam logic [7:0]       PAD_CHAR = 8'h3D;
	localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_PADDING  = 2'd1,
		ERR_INVALID  = 2'd2,
		ERR_AFTER_PAD = 2'd3
	} err_t;

	// one queue entry: the bytes of a quantum and an optional status
	typedef struct packed {
		logic [1:0]       nbytes;
		logic [2:0][7:0]  bytes;
		logic             status;
		err_t             err;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// bit 6 set marks a character outside the alphabet; padding maps to zero
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] s;
		s = 7'h40;
		if (c inside {[8'h41:8'h5A]}) begin
			s = {1'b0, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			s = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			s = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			s = {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			s = {1'b0, 6'd63};
		end else if (c == PAD_CHAR) begin
			s = 7'h00;
		end
		return s;
	endfunction

endpackage

>>> hdl/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: one text character and its flags per transaction.
// ----------------------------------------------------------------------------
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       char_present;
	logic       end_of_text;

	modport source (output valid, char_code, char_present, end_of_text, input ready);
	modport sink (input valid, char_code, char_present, end_of_text, output ready);
endinterface

>>> hdl/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: a decoded byte or the final status per transaction.
// ----------------------------------------------------------------------------
interface b64d_out_if
	import b64d_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             item_kind;
	logic [7:0]       data_byte;
	logic [1:0]       error_code;
	logic [LEN_W-1:0] decoded_length;
	logic             last_of_run;

	modport source (output valid, item_kind, data_byte, error_code, decoded_length,
		last_of_run, input ready);
	modport sink (input valid, item_kind, data_byte, error_code, decoded_length,
		last_of_run, output ready);
endinterface

>>> hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, collects quanta, checks and decodes them, keeps the
// error and byte count, and pushes one queue entry per valid quantum or end.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	b64d_in_if.sink     chars,
	input  logic        full,
	output logic        push,
	output cmd_t        push_data
);

	localparam int XW = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

	logic [2:0][7:0]       qchar_q;
	logic [1:0]            pos_q;
	logic                  pad_q;
	err_t                  err_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  take, live, quad, quad_ok;
	logic [6:0]            s0, s1, s2, s3;
	logic                  p0, p1, p2, p3, any_bad;
	err_t                  q_err, err_nx;
	logic [1:0]            nb;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] count_nx;
	logic [XW-1:0]         count_x;

	assign chars.ready = !full;
	assign take = chars.valid && chars.ready;
	assign live = chars.char_present && (err_q == ERR_NONE);
	assign quad = take && live && (pos_q == 2'd3);

	assign s0 = sextet_of(qchar_q[0]);
	assign s1 = sextet_of(qchar_q[1]);
	assign s2 = sextet_of(qchar_q[2]);
	assign s3 = sextet_of(chars.char_code);
	assign p0 = (qchar_q[0] == PAD_CHAR);
	assign p1 = (qchar_q[1] == PAD_CHAR);
	assign p2 = (qchar_q[2] == PAD_CHAR);
	assign p3 = (chars.char_code == PAD_CHAR);
	assign any_bad = s0[6] | s1[6] | s2[6] | s3[6];

	// precedence: data after padding, misplaced padding, invalid character
	always_comb begin
		if (pad_q) begin
			q_err = ERR_AFTER_PAD;
		end else if (p0 || p1 || (p2 && !p3)) begin
			q_err = ERR_PADDING;
		end else if (any_bad) begin
			q_err = ERR_INVALID;
		end else begin
			q_err = ERR_NONE;
		end
	end

	assign nb      = p2 ? 2'd1 : (p3 ? 2'd2 : 2'd3);
	assign quad_ok = quad && (q_err == ERR_NONE);
	assign err_nx  = quad ? q_err : err_q;

	// saturating count
	assign sum      = {1'b0, count_q} + (COUNT_BITS+1)'(nb);
	assign count_nx = !quad_ok ? count_q :
		(sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0]);
	assign count_x  = XW'(count_nx);

	always_comb begin
		push_data.nbytes   = quad_ok ? nb : 2'd0;
		push_data.bytes[0] = {s0[5:0], s1[5:4]};
		push_data.bytes[1] = {s1[3:0], s2[5:2]};
		push_data.bytes[2] = {s2[1:0], s3[5:0]};
		push_data.status   = chars.end_of_text;
		push_data.err      = err_nx;
		if (err_nx != ERR_NONE) begin
			push_data.len = '0;
		end else if (count_x > XW'(LEN_MAX)) begin
			push_data.len = LEN_MAX;
		end else begin
			push_data.len = LEN_W'(count_x);
		end
	end

	assign push = take && (quad_ok || chars.end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			pad_q   <= 1'b0;
			err_q   <= ERR_NONE;
			count_q <= '0;
		end else if (take) begin
			if (chars.end_of_text) begin
				pos_q   <= 2'd0;
				pad_q   <= 1'b0;
				err_q   <= ERR_NONE;
				count_q <= '0;
			end else if (live) begin
				if (pos_q != 2'd3) begin
					pos_q <= pos_q + 2'd1;
				end else begin
					pos_q   <= 2'd0;
					err_q   <= err_nx;
					count_q <= count_nx;
					if (quad_ok && nb != 2'd3) begin
						pad_q <= 1'b1;
					end
				end
			end
		end
	end

	// held characters of the quantum, no reset needed
	always_ff @(posedge clk) begin
		if (take && live && pos_q != 2'd3) begin
			qchar_q[pos_q] <= chars.char_code;
		end
	end

endmodule

>>> hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short register queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module b64d_queue
	import b64d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH)) else $error("queue count out of range");

endmodule

>>> hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Walks each queue entry into the output register one result per free cycle.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	b64d_out_if.source results
);

	logic             valid_q;
	logic             kind_q;
	logic [7:0]       byte_q;
	logic [1:0]       err_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;
	logic [1:0]       idx_q;

	logic             load, last, is_status;
	logic [2:0]       n_res;
	logic [7:0]       sel_byte;

	assign load      = !empty && (!valid_q || results.ready);
	assign n_res     = {1'b0, head.nbytes} + {2'b00, head.status};
	assign last      = ({1'b0, idx_q} == n_res - 3'd1);
	assign is_status = head.status && (idx_q == head.nbytes);
	assign pop       = load && last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			2'd2:    sel_byte = head.bytes[2];
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= is_status ? KIND_STATUS : KIND_DATA;
			byte_q <= is_status ? 8'd0 : sel_byte;
			err_q  <= is_status ? head.err : ERR_NONE;
			len_q  <= is_status ? head.len : '0;
			last_q <= last;
		end
	end

	assign results.valid          = valid_q;
	assign results.item_kind      = kind_q;
	assign results.data_byte      = byte_q;
	assign results.error_code     = err_q;
	assign results.decoded_length = len_q;
	assign results.last_of_run    = last_q;

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, idx_q} < n_res)) else $error("result index past entry");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> idx_q == 2'd0) else $error("result index left over");

endmodule

>>> hdl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming base64 decoder: text characters in, bytes and a status out.
// ----------------------------------------------------------------------------
// usage
//   chars   : one transaction per text character (char_present set) or an
//             end-only transaction; end_of_text closes the text after it
//   results : decoded bytes (item_kind 0) in order, then at end of text one
//             status transaction with the first error and the byte count;
//             last_of_run marks the final result of each queue entry
// timing
//   a character is taken every cycle while the entry queue has room; the
//   fourth character of a quantum is checked and decoded in the cycle it
//   is taken, and its results then pass through the entry queue and the
//   output register before they are presented
//   results leave at one per cycle when not stalled, via the output register,
//   so a quantum (up to three bytes plus status) never outruns four characters
// stalls
//   a stalled receiver holds the output register; the four-entry queue then
//   fills and chars.ready drops until the receiver takes results again
// reset
//   arst_n clears quantum position, padding flag, error, count and queue;
//   after every end_of_text transaction the decoder also starts a fresh text
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
	import b64d_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	b64d_in_if.sink    chars,
	b64d_out_if.source results
);

	// entry handshake between the decoding front and the result back
	logic push, full, pop, empty;
	cmd_t push_data, head;

	// front: quantum collection, checks, decode and saturating count
	b64d_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	// queue: lets the front run on while results wait downstream
	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// back: one result transaction per cycle from the head entry, unless stalled
	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.results(results)
	);

endmodule
